@@ rtl/sip_pkg.sv @@
package sip_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int MODE_W     = 2;
	localparam int SLOTF_W    = 8;
	localparam int TIME_W     = 64;
	localparam int RUN_W      = 32;
	localparam int CLK_W      = 14;
	localparam int OVH_W      = 16;
	localparam int IN_DATA_W  = SLOTF_W + TIME_W;
	localparam int OUT_DATA_W = 2 * TIME_W + RUN_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_MHZ     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_OVERHEAD = 2'd1;
	localparam logic [CLK_W-1:0]     CLOCK_MHZ_RESET   = 14'd1000;

	localparam int DVSR_W    = 32;
	localparam int DIV_CNT_W = $clog2(TIME_W);

	typedef enum logic [MODE_W-1:0] {
		MODE_START,
		MODE_STOP,
		MODE_ACCOUNT,
		MODE_READ
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_UPD,
		ST_PREP,
		ST_SCALE,
		ST_DIV_LAT,
		ST_WAIT_LAT,
		ST_DIV_AVG1,
		ST_WAIT_AVG1,
		ST_DIV_AVG2,
		ST_WAIT_AVG2,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		DSEL_LAT,
		DSEL_AVG1,
		DSEL_AVG2
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     load;
		logic     upd;
		logic     prep;
		logic     scale;
		logic     div_start;
		div_sel_t div_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic invalid;
		logic n_zero;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/sip_div.sv @@
module sip_div import sip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [DVSR_W-1:0] divisor,
	output logic [TIME_W-1:0] quotient,
	output logic              done
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]    dvd_q;
	logic [DVSR_W-1:0]    rem_q;
	logic [DVSR_W-1:0]    dvsr_q;
	logic [DVSR_W:0]      rem_sh;
	logic                 ge;
	logic [DVSR_W:0]      rem_n;

	// restoring step: shift in one dividend bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q, dvd_q[TIME_W-1]};
		ge     = rem_sh >= {1'b0, dvsr_q};
		rem_n  = ge ? rem_sh - {1'b0, dvsr_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvsr_q <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_W-2:0], ge};
			rem_q <= rem_n[DVSR_W-1:0];
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

@@ rtl/sip_ctrl.sv @@
module sip_ctrl import sip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = DSEL_LAT;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.invalid) begin
					state_d = ST_DONE;
				end else begin
					cmd.load = 1'b1;
					state_d  = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = sts.n_zero ? ST_DONE : ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_DIV_LAT;
			end
			ST_DIV_LAT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_LAT;
				state_d       = ST_WAIT_LAT;
			end
			ST_WAIT_LAT: begin
				if (sts.div_done) state_d = ST_DIV_AVG1;
			end
			ST_DIV_AVG1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_AVG1;
				state_d       = ST_WAIT_AVG1;
			end
			ST_WAIT_AVG1: begin
				if (sts.div_done) state_d = ST_DIV_AVG2;
			end
			ST_DIV_AVG2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_AVG2;
				state_d       = ST_WAIT_AVG2;
			end
			ST_WAIT_AVG2: begin
				if (sts.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/sip_dp.sv @@
module sip_dp import sip_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [MODE_W-1:0]     in_tuser,
	input  logic [IN_DATA_W-1:0]  in_tdata,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_tready,
	output logic                  out_tvalid,
	output logic [OUT_DATA_W-1:0] out_tdata,
	output logic                  out_tuser
);

	logic [TIME_W-1:0] start_time    [SLOT_COUNT];
	logic [TIME_W-1:0] last_interval [SLOT_COUNT];
	logic [TIME_W-1:0] interval_sum  [SLOT_COUNT];
	logic [RUN_W-1:0]  runs          [SLOT_COUNT];

	logic [CLK_W-1:0]   clk_mhz_q;
	logic [OVH_W-1:0]   ovh_q;
	mode_t              mode_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [TIME_W-1:0]  time_q;
	logic               invalid_q;
	logic [TIME_W-1:0]  iv_q;
	logic [TIME_W-1:0]  last_q;
	logic [TIME_W-1:0]  sum_q;
	logic [RUN_W-1:0]   n_q;
	logic [TIME_W-1:0]  num_lat_q;
	logic [TIME_W-1:0]  num_avg_q;
	logic [TIME_W-1:0]  latest_q;
	logic [TIME_W-1:0]  average_q;
	div_sel_t           div_sel_q;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_tdata_q;
	logic               out_tuser_q;

	logic [SLOT_W-1:0]        si;
	logic [CLK_W-1:0]         clk_div;
	logic [OVH_W+RUN_W-1:0]   ovh_runs;
	logic                     records;
	logic [TIME_W-1:0]        div_dividend;
	logic [DVSR_W-1:0]        div_divisor;
	logic [TIME_W-1:0]        div_quotient;
	logic                     div_done;

	// x * 1000 as 1024x - 32x + 8x, modulo 2^64
	function automatic logic [TIME_W-1:0] times1000(input logic [TIME_W-1:0] x);
		return (x << 10) - (x << 5) + (x << 3);
	endfunction

	assign si       = slot_q;
	assign clk_div  = (clk_mhz_q == '0) ? CLK_W'(1) : clk_mhz_q;
	assign ovh_runs = ovh_q * n_q;
	assign records  = (mode_q == MODE_STOP) || (mode_q == MODE_ACCOUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_mhz_q <= CLOCK_MHZ_RESET;
			ovh_q     <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_CLOCK_MHZ) begin
				clk_mhz_q <= cfg_data[CLK_W-1:0];
			end else if (cfg_index == CFG_TICK_OVERHEAD) begin
				ovh_q <= cfg_data[OVH_W-1:0];
			end
		end
	end

	// slot table; 16 entries read at one address, kept in flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				start_time[i]    <= '0;
				last_interval[i] <= '0;
				interval_sum[i]  <= '0;
				runs[i]          <= '0;
			end
		end else if (cmd.upd) begin
			if (mode_q == MODE_START) begin
				start_time[si] <= time_q;
			end else if (records) begin
				last_interval[si] <= iv_q;
				interval_sum[si]  <= sum_q + iv_q;
				runs[si]          <= n_q + RUN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q    <= mode_t'(in_tuser);
			slot_q    <= in_tdata[SLOT_W-1:0];
			time_q    <= in_tdata[IN_DATA_W-1:SLOTF_W];
			invalid_q <= {1'b0, in_tdata[SLOTF_W-1:0]} >= (SLOTF_W + 1)'(SLOT_COUNT);
		end
		if (cmd.load) begin
			iv_q   <= (mode_q == MODE_STOP) ? time_q - start_time[si] : time_q;
			last_q <= last_interval[si];
			sum_q  <= interval_sum[si];
			n_q    <= runs[si];
		end
		if (cmd.upd && records) begin
			last_q <= iv_q;
			sum_q  <= sum_q + iv_q;
			n_q    <= n_q + RUN_W'(1);
		end
		if (cmd.prep) begin
			num_lat_q <= last_q - TIME_W'(ovh_q);
			num_avg_q <= sum_q - TIME_W'(ovh_runs);
		end
		if (cmd.scale) begin
			num_lat_q <= times1000(num_lat_q);
			num_avg_q <= times1000(num_avg_q);
		end
		if (cmd.div_start) begin
			div_sel_q <= cmd.div_sel;
		end
		if (div_done) begin
			unique case (div_sel_q)
				DSEL_LAT:  latest_q  <= div_quotient;
				DSEL_AVG1: num_avg_q <= div_quotient;
				DSEL_AVG2: average_q <= div_quotient;
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.div_sel)
			DSEL_LAT: begin
				div_dividend = num_lat_q;
				div_divisor  = DVSR_W'(clk_div);
			end
			DSEL_AVG1: begin
				div_dividend = num_avg_q;
				div_divisor  = n_q;
			end
			DSEL_AVG2: begin
				div_dividend = num_avg_q;
				div_divisor  = DVSR_W'(clk_div);
			end
			default: begin
				div_dividend = num_lat_q;
				div_divisor  = DVSR_W'(clk_div);
			end
		endcase
	end

	sip_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quotient),
		.done     (div_done)
	);

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_tuser_q <= invalid_q;
			if (invalid_q) begin
				out_tdata_q <= '0;
			end else if (n_q == '0) begin
				out_tdata_q <= '0;
			end else begin
				out_tdata_q <= {n_q, average_q, latest_q};
			end
		end
	end

	assign sts.invalid  = invalid_q;
	assign sts.n_zero   = (n_q == '0);
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_tready;

	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_tdata_q;
	assign out_tuser  = out_tuser_q;

	a_load_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_tready))
		else $error("result beat overwritten before it was taken");

	a_run_increment: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd && ((mode_q == MODE_STOP) || (mode_q == MODE_ACCOUNT)))
		|=> (n_q == ($past(n_q) + RUN_W'(1))))
		else $error("run count did not advance on a recorded run");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_tuser_q) |-> (out_tdata_q == '0))
		else $error("invalid slot result carries nonzero data");

endmodule

@@ rtl/slotted_interval_profiler_unit.sv @@
// Flow: for a valid slot with runs the result takes three 64-step passes of the shared
// radix-2 divider; an out-of-range slot or a slot whose run count is zero skips the divider.
// One item in flight at a time; the next input beat is taken the cycle after the result
// is loaded into the output register, and that load waits while the previous result is
// still untaken. Reset clears the slot table and control state, clock_mhz 1000, overhead 0.
module slotted_interval_profiler_unit import sip_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // slot[7:0], time_value[71:8]
	input  logic [MODE_W-1:0]     s_axis_tuser,  // mode[1:0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // latest_ns[63:0], average_ns[127:64],
	                                             // run_count[159:128]
	output logic                  m_axis_tuser,  // slot_invalid[0]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	sip_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sip_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_tuser   (s_axis_tuser),
		.in_tdata   (s_axis_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_tready (m_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser)
	);

endmodule
